>>> sv/u8d_pkg.sv
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and constants of the UTF-8 decoder with replacement.
// ----------------------------------------------------------------------------
package u8d_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;
  localparam logic [20:0] CP_MAX         = 21'h10FFFF;
  localparam logic [20:0] CP_SURR_LO     = 21'h00D800;
  localparam logic [20:0] CP_SURR_HI     = 21'h00DFFF;
  localparam logic [20:0] CP_TIMES       = 21'h0000D7;
  localparam logic [20:0] CP_LETTER_X    = 21'h000078;
  localparam logic [20:0] CP_MIN_2       = 21'h000080;
  localparam logic [20:0] CP_MIN_3       = 21'h000800;
  localparam logic [20:0] CP_MIN_4       = 21'h010000;

  localparam logic [7:0] LEAD2_LO = 8'hC2;
  localparam logic [7:0] LEAD2_HI = 8'hDF;
  localparam logic [7:0] LEAD3_LO = 8'hE0;
  localparam logic [7:0] LEAD3_HI = 8'hEF;
  localparam logic [7:0] LEAD4_LO = 8'hF0;
  localparam logic [7:0] LEAD4_HI = 8'hF4;

  localparam logic [2:0] SEQ_NONE = 3'd0;
  localparam logic [2:0] SEQ_TWO  = 3'd2;
  localparam logic [2:0] SEQ_THREE = 3'd3;
  localparam logic [2:0] SEQ_FOUR = 3'd4;

  // Results caused by one word: n_repl replacements, then an optional code point.
  typedef struct packed {
    logic [2:0]  n_repl;
    logic        has_cp;
    logic [20:0] cp;
    logic        end_name;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

>>> sv/u8d_if.sv
// ----------------------------------------------------------------------------
// u8d_if
// Valid/ready channels of the decoder: raw byte words in, code point words out.
// ----------------------------------------------------------------------------
interface u8d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_name;

  modport source (output valid, output data_byte, output end_of_name, input ready);
  modport sink   (input valid, input data_byte, input end_of_name, output ready);
endinterface

interface u8d_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic        replaced;
  logic        last_of_run;
  logic        name_done;

  modport source (output valid, output code_point, output replaced,
                  output last_of_run, output name_done, input ready);
  modport sink   (input valid, input code_point, input replaced,
                  input last_of_run, input name_done, output ready);
endinterface

>>> sv/utf8_decoder_with_replacement.sv
// ----------------------------------------------------------------------------
// utf8_decoder_with_replacement
// UTF-8 decoder: byte words in, code point words out, with U+FFFD replacement.
//
//   channel | dir | handshake         | payload
//   in_ch   | in  | valid/ready       | data_byte[7:0], end_of_name
//   out_ch  | out | valid/ready       | code_point[20:0], replaced, last_of_run,
//           |     |                   | name_done
//
// One byte word accepted per cycle while the descriptor queue has room.
// A byte word yields zero to four result words; the expander sends one per
// cycle while out_ch.ready does not stall it.
// A byte's results pass through the descriptor queue, then the output register.
// Synchronous active-low reset clears sequence state, queue and output valid.
// Output stalls back up to in_ch.ready once QUEUE_DEPTH descriptors wait behind
// the output register; byte words that cause no result take no queue slot.
// ----------------------------------------------------------------------------
module utf8_decoder_with_replacement #(
  parameter int unsigned QUEUE_DEPTH = u8d_pkg::QUEUE_DEPTH
) (
  input logic              clk,
  input logic              rst_n,
  u8d_in_if.sink           in_ch,
  u8d_out_if.source        out_ch
);

  logic             accept;
  logic             push;
  logic             pop;
  u8d_pkg::desc_t   push_desc;
  u8d_pkg::desc_t   head;
  u8d_pkg::q_stat_t stat;

  assign in_ch.ready = !stat.full;
  assign accept      = in_ch.valid && !stat.full;

  u8d_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .data_byte   (in_ch.data_byte),
    .end_of_name (in_ch.end_of_name),
    .push        (push),
    .desc        (push_desc)
  );

  u8d_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .stat      (stat)
  );

  u8d_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .stat        (stat),
    .pop         (pop),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .code_point  (out_ch.code_point),
    .replaced    (out_ch.replaced),
    .last_of_run (out_ch.last_of_run),
    .name_done   (out_ch.name_done)
  );

endmodule

>>> sv/u8d_front.sv
// ----------------------------------------------------------------------------
// u8d_front
// Sequence tracker: classifies each byte, emits a descriptor if it has results.
// ----------------------------------------------------------------------------
module u8d_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  logic [7:0]     data_byte,
  input  logic           end_of_name,
  output logic           push,
  output u8d_pkg::desc_t desc
);

  logic [2:0]  len_r, len_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [20:0] pv_r, pv_nxt;

  logic [20:0] pv_shift;
  logic [2:0]  cnt_inc;
  logic [20:0] minimum;
  logic        value_ok;
  logic        is_cont;
  logic        consumed;
  logic [2:0]  n_repl;
  logic        has_cp;
  logic [20:0] cp;
  logic [2:0]  total;

  assign pv_shift = {pv_r[14:0], data_byte[5:0]};
  assign cnt_inc  = {1'b0, cnt_r} + 3'd1;
  assign is_cont  = (data_byte[7:6] == 2'b10);

  always_comb begin
    case (len_r)
      u8d_pkg::SEQ_TWO:   minimum = u8d_pkg::CP_MIN_2;
      u8d_pkg::SEQ_THREE: minimum = u8d_pkg::CP_MIN_3;
      default:            minimum = u8d_pkg::CP_MIN_4;
    endcase
  end

  assign value_ok = (pv_shift >= minimum) && (pv_shift <= u8d_pkg::CP_MAX) &&
                    !((pv_shift >= u8d_pkg::CP_SURR_LO) && (pv_shift <= u8d_pkg::CP_SURR_HI));

  always_comb begin
    len_nxt  = len_r;
    cnt_nxt  = cnt_r;
    pv_nxt   = pv_r;
    n_repl   = 3'd0;
    has_cp   = 1'b0;
    cp       = {13'd0, data_byte};
    consumed = 1'b0;

    if (len_r != u8d_pkg::SEQ_NONE) begin
      if (is_cont) begin
        consumed = 1'b1;
        if ((cnt_inc + 3'd1) >= len_r) begin
          if (value_ok) begin
            has_cp = 1'b1;
            cp     = (pv_shift == u8d_pkg::CP_TIMES) ? u8d_pkg::CP_LETTER_X : pv_shift;
          end else begin
            n_repl = len_r;
          end
          len_nxt = u8d_pkg::SEQ_NONE;
          cnt_nxt = 2'd0;
          pv_nxt  = 21'd0;
        end else begin
          pv_nxt  = pv_shift;
          cnt_nxt = cnt_inc[1:0];
        end
      end else begin
        // breaking byte: flush buffered bytes, decode it as a new byte below
        n_repl  = cnt_inc;
        len_nxt = u8d_pkg::SEQ_NONE;
        cnt_nxt = 2'd0;
        pv_nxt  = 21'd0;
      end
    end

    if (!consumed) begin
      if (!data_byte[7]) begin
        has_cp = 1'b1;
        cp     = {13'd0, data_byte};
      end else if (data_byte >= u8d_pkg::LEAD2_LO && data_byte <= u8d_pkg::LEAD2_HI) begin
        len_nxt = u8d_pkg::SEQ_TWO;
        cnt_nxt = 2'd0;
        pv_nxt  = {16'd0, data_byte[4:0]};
      end else if (data_byte >= u8d_pkg::LEAD3_LO && data_byte <= u8d_pkg::LEAD3_HI) begin
        len_nxt = u8d_pkg::SEQ_THREE;
        cnt_nxt = 2'd0;
        pv_nxt  = {17'd0, data_byte[3:0]};
      end else if (data_byte >= u8d_pkg::LEAD4_LO && data_byte <= u8d_pkg::LEAD4_HI) begin
        len_nxt = u8d_pkg::SEQ_FOUR;
        cnt_nxt = 2'd0;
        pv_nxt  = {18'd0, data_byte[2:0]};
      end else begin
        n_repl = n_repl + 3'd1;
      end
    end

    if (end_of_name) begin
      if (len_nxt != u8d_pkg::SEQ_NONE) begin
        n_repl = n_repl + 3'd1 + {1'b0, cnt_nxt};
      end
      len_nxt = u8d_pkg::SEQ_NONE;
      cnt_nxt = 2'd0;
      pv_nxt  = 21'd0;
    end
  end

  assign total = n_repl + {2'd0, has_cp};
  assign push  = accept && (total != 3'd0);

  assign desc.n_repl   = n_repl;
  assign desc.has_cp   = has_cp;
  assign desc.cp       = cp;
  assign desc.end_name = end_of_name;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= u8d_pkg::SEQ_NONE;
      cnt_r <= 2'd0;
      pv_r  <= 21'd0;
    end else if (accept) begin
      len_r <= len_nxt;
      cnt_r <= cnt_nxt;
      pv_r  <= pv_nxt;
    end
  end

endmodule

>>> sv/u8d_fifo.sv
// ----------------------------------------------------------------------------
// u8d_fifo
// Short descriptor queue between the sequence tracker and the result expander.
// ----------------------------------------------------------------------------
module u8d_fifo #(
  parameter int unsigned DEPTH = u8d_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  u8d_pkg::desc_t    push_desc,
  input  logic              pop,
  output u8d_pkg::desc_t    head,
  output u8d_pkg::q_stat_t  stat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  u8d_pkg::desc_t mem_r [DEPTH];

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == CNT_FULL);
  assign stat.empty = (cnt_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

>>> sv/u8d_back.sv
// ----------------------------------------------------------------------------
// u8d_back
// Result expander: turns each descriptor into its code point words, one per
// cycle while out_ready allows, through an output register.
// ----------------------------------------------------------------------------
module u8d_back (
  input  logic             clk,
  input  logic             rst_n,
  input  u8d_pkg::desc_t   head,
  input  u8d_pkg::q_stat_t stat,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [20:0]      code_point,
  output logic             replaced,
  output logic             last_of_run,
  output logic             name_done
);

  logic [1:0]  idx_r, idx_nxt;
  logic        valid_r, valid_nxt;
  logic [20:0] cp_r;
  logic        repl_r, last_r, done_r;

  logic        load;
  logic        take;
  logic [2:0]  total;
  logic        item_last;
  logic        item_repl;

  assign load      = !valid_r || out_ready;
  assign take      = load && !stat.empty;
  assign total     = head.n_repl + {2'd0, head.has_cp};
  assign item_last = ({1'b0, idx_r} == (total - 3'd1));
  assign item_repl = ({1'b0, idx_r} < head.n_repl);
  assign pop       = take && item_last;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = !stat.empty;
    end
    if (take) begin
      idx_nxt = item_last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cp_r   <= item_repl ? u8d_pkg::CP_REPLACEMENT : head.cp;
      repl_r <= item_repl;
      last_r <= item_last;
      done_r <= item_last && head.end_name;
    end
  end

  assign out_valid   = valid_r;
  assign code_point  = cp_r;
  assign replaced    = repl_r;
  assign last_of_run = last_r;
  assign name_done   = done_r;

endmodule

>>> sv/u8d_checker.sv
// ----------------------------------------------------------------------------
// u8d_checker
// Port-level checks of the decoder output, bound to the top level.
// ----------------------------------------------------------------------------
module u8d_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [20:0] out_code_point,
  input logic        out_replaced,
  input logic        out_last_of_run,
  input logic        out_name_done
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_code_point) &&
                                $stable(out_replaced) && $stable(out_last_of_run) &&
                                $stable(out_name_done))
    else $error("output word changed while stalled");

  a_repl_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_replaced |-> out_code_point == u8d_pkg::CP_REPLACEMENT)
    else $error("replaced word without U+FFFD");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_name_done |-> out_last_of_run)
    else $error("name end not on last word of run");

  a_cp_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_code_point <= u8d_pkg::CP_MAX &&
                  out_code_point != u8d_pkg::CP_TIMES &&
                  !(out_code_point >= u8d_pkg::CP_SURR_LO &&
                    out_code_point <= u8d_pkg::CP_SURR_HI))
    else $error("illegal code point on output");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind utf8_decoder_with_replacement u8d_checker u_u8d_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_code_point  (out_ch.code_point),
  .out_replaced    (out_ch.replaced),
  .out_last_of_run (out_ch.last_of_run),
  .out_name_done   (out_ch.name_done)
);
